### hdl/ctp_pkg.sv
// Shared types and constants for the CIDR text parser.
// No dependencies; imported by ctp_scan, ctp_calc and cidr_text_parser.
package ctp_pkg;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 200;
  localparam int unsigned IDX_W      = 6;

  // Characters kept per string; later characters only count toward the last marker.
  localparam logic [IDX_W-1:0] MAX_CHARS = 6'd31;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [5:0] PREFIX_MAX = 6'd32;
  localparam logic [5:0] PREFIX_P2P = 6'd31;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLASH = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Outcome of one string, handed from the scanner to the calculator.
  typedef struct packed {
    status_t     status;
    logic [5:0]  prefix;
    logic [31:0] address;
  } summary_t;

  // Result word; the last member sits in the lowest bits of tdata.
  typedef struct packed {
    logic [31:0] host_count;
    logic [31:0] host_high;
    logic [31:0] host_low;
    logic [31:0] broadcast;
    logic [31:0] netmask;
    logic [31:0] network;
    logic [5:0]  prefix_length;
    status_t     status;
  } result_t;

endpackage

### hdl/cidr_text_parser.sv
// Top level of the IPv4 CIDR text parser: scanner stage and calculator stage.
// Depends on ctp_pkg, ctp_scan and ctp_calc.
//
// Usage: feed the CIDR text one character per word on the s_ channel
// (s_tdata = character code, s_tlast = final character of the string).
// Only the first 31 characters are parsed and a NUL ends the content;
// further characters are still taken, so the string ends only at s_tlast.
// Every word carrying s_tlast yields exactly one result word on the m_
// channel: status, prefix length, network, netmask, broadcast, first and
// last host and host count. On any error status all other fields are zero.
// Throughput: one character per cycle while s_tready is high. The last
// character's outcome goes into the summary register, then the result into
// the output register, where m_tvalid rises and the result word waits.
// When the receiver stalls, both stages fill and s_tready
// drops only while a finished summary cannot move on; characters that are not
// the last of a string still need that summary slot free.
// Reset (rst, synchronous) clears the parse state and both valid flags, so
// the next character starts a new string.
module cidr_text_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ctp_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] char_code
  input  logic                           s_tlast,   // last
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] status, [7:2] prefix_length, [39:8] network, [71:40] netmask,
  // [103:72] broadcast, [135:104] host_low, [167:136] host_high,
  // [199:168] host_count
  output logic [ctp_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ctp_pkg::*;

  logic     sum_valid;
  logic     sum_ready;
  summary_t sum;
  result_t  res_view;

  ctp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  ctp_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  assign res_view = m_tdata;

  // A taken last character always leaves a summary behind
  a_last_makes_summary: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> sum_valid)
    else $error("last character did not produce a summary");

  // Error results carry nothing but the status
  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_view.status != ST_OK) |-> (m_tdata[OUT_DATA_W-1:2] == '0))
    else $error("error result with nonzero fields");

  // Good results keep the prefix in range and the broadcast consistent
  a_ok_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_view.status == ST_OK) |->
      (res_view.prefix_length <= PREFIX_MAX) &&
      (res_view.broadcast == (res_view.network | ~res_view.netmask)))
    else $error("inconsistent good result");

  // A summary waiting on a stalled output must hold still
  a_summary_holds: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !sum_ready |=> sum_valid && $stable(sum))
    else $error("summary changed while stalled");

endmodule

### hdl/ctp_scan.sv
// Character scanner: per-string parse state and the registered summary stage.
// Depends on ctp_pkg.
module ctp_scan (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ctp_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                               s_tlast,
  output logic                               sum_valid,
  input  logic                               sum_ready,
  output ctp_pkg::summary_t                  sum
);
  import ctp_pkg::*;

  logic [IDX_W-1:0] char_index, char_index_next;
  logic             in_prefix, in_prefix_next;
  logic             content_ended, content_ended_next;
  logic [1:0]       octet_index, octet_index_next;
  logic [7:0]       octet_value, octet_value_next;
  logic [1:0]       octet_digits, octet_digits_next;
  logic [31:0]      address_acc, address_acc_next;
  logic             address_bad, address_bad_next;
  logic [5:0]       prefix_value, prefix_value_next;
  logic             prefix_over, prefix_over_next;
  phase_t           prefix_phase, prefix_phase_next;
  logic             prefix_negative, prefix_negative_next;
  summary_t         sum_next;

  logic       accept;
  logic [7:0] ch;
  logic       is_digit, is_white;
  logic [3:0] dval;
  logic [11:0] octet_mul;
  logic [9:0]  prefix_mul;

  assign s_tready = !sum_valid || sum_ready;
  assign accept   = s_tvalid && s_tready;
  assign ch       = s_tdata;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_white = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign dval     = ch[3:0];
  assign octet_mul  = ({4'd0, octet_value} << 3) + ({4'd0, octet_value} << 1) + {8'd0, dval};
  assign prefix_mul = ({4'd0, prefix_value} << 3) + ({4'd0, prefix_value} << 1) + {6'd0, dval};

  always_comb begin
    phase_t ph;
    logic   take;
    ph   = prefix_phase;
    take = 1'b1;

    char_index_next      = char_index;
    in_prefix_next       = in_prefix;
    content_ended_next   = content_ended;
    octet_index_next     = octet_index;
    octet_value_next     = octet_value;
    octet_digits_next    = octet_digits;
    address_acc_next     = address_acc;
    address_bad_next     = address_bad;
    prefix_value_next    = prefix_value;
    prefix_over_next     = prefix_over;
    prefix_phase_next    = prefix_phase;
    prefix_negative_next = prefix_negative;
    sum_next             = sum;

    if (accept) begin
      if (!content_ended && (char_index < MAX_CHARS)) begin
        char_index_next = char_index + 1'b1;
        if (ch == CH_NUL) begin
          content_ended_next = 1'b1;
        end else if (in_prefix) begin
          // atoi style: skip white space, optional sign, then digits
          if (ph == PH_SKIP) begin
            if (is_white) begin
              take = 1'b0;
            end else begin
              ph = PH_DIGITS;
              if (ch == CH_PLUS) begin
                take = 1'b0;
              end else if (ch == CH_MINUS) begin
                prefix_negative_next = 1'b1;
                take = 1'b0;
              end
            end
          end
          if (take && (ph == PH_DIGITS)) begin
            if (!is_digit) begin
              ph = PH_DONE;
            end else if (!prefix_over) begin
              if (prefix_mul > {4'd0, PREFIX_MAX}) prefix_over_next = 1'b1;
              else prefix_value_next = prefix_mul[5:0];
            end
          end
          prefix_phase_next = ph;
        end else if (ch == CH_SLASH) begin
          in_prefix_next = 1'b1;
          if (!address_bad) begin
            if ((octet_digits == 2'd0) || (octet_index != 2'd3)) address_bad_next = 1'b1;
            else address_acc_next = {address_acc[23:0], octet_value};
          end
        end else if (!address_bad) begin
          if (is_digit) begin
            if ((octet_digits != 2'd0) && (octet_value == 8'd0)) begin
              address_bad_next = 1'b1;
            end else if (octet_mul > 12'd255) begin
              address_bad_next = 1'b1;
            end else begin
              octet_value_next = octet_mul[7:0];
              if (octet_digits != 2'd3) octet_digits_next = octet_digits + 1'b1;
            end
          end else if (ch == CH_DOT) begin
            if ((octet_digits == 2'd0) || (octet_index == 2'd3)) begin
              address_bad_next = 1'b1;
            end else begin
              address_acc_next  = {address_acc[23:0], octet_value};
              octet_index_next  = octet_index + 1'b1;
              octet_value_next  = 8'd0;
              octet_digits_next = 2'd0;
            end
          end else begin
            address_bad_next = 1'b1;
          end
        end
      end

      if (s_tlast) begin
        sum_next.prefix  = prefix_value_next;
        sum_next.address = address_acc_next;
        if (!in_prefix_next) sum_next.status = ST_NO_SLASH;
        else if (address_bad_next) sum_next.status = ST_BAD_ADDR;
        else if (prefix_over_next || (prefix_negative_next && (prefix_value_next != 6'd0)))
          sum_next.status = ST_RANGE;
        else sum_next.status = ST_OK;

        // Start the next string from a clean state
        char_index_next      = '0;
        in_prefix_next       = 1'b0;
        content_ended_next   = 1'b0;
        octet_index_next     = 2'd0;
        octet_value_next     = 8'd0;
        octet_digits_next    = 2'd0;
        address_acc_next     = 32'd0;
        address_bad_next     = 1'b0;
        prefix_value_next    = 6'd0;
        prefix_over_next     = 1'b0;
        prefix_phase_next    = PH_SKIP;
        prefix_negative_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_index      <= '0;
      in_prefix       <= 1'b0;
      content_ended   <= 1'b0;
      octet_index     <= 2'd0;
      octet_value     <= 8'd0;
      octet_digits    <= 2'd0;
      address_acc     <= 32'd0;
      address_bad     <= 1'b0;
      prefix_value    <= 6'd0;
      prefix_over     <= 1'b0;
      prefix_phase    <= PH_SKIP;
      prefix_negative <= 1'b0;
      sum_valid       <= 1'b0;
    end else begin
      char_index      <= char_index_next;
      in_prefix       <= in_prefix_next;
      content_ended   <= content_ended_next;
      octet_index     <= octet_index_next;
      octet_value     <= octet_value_next;
      octet_digits    <= octet_digits_next;
      address_acc     <= address_acc_next;
      address_bad     <= address_bad_next;
      prefix_value    <= prefix_value_next;
      prefix_over     <= prefix_over_next;
      prefix_phase    <= prefix_phase_next;
      prefix_negative <= prefix_negative_next;
      if (sum_ready || !sum_valid) sum_valid <= accept && s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

endmodule

### hdl/ctp_calc.sv
// Network value calculator: mask, network, broadcast, host range and count.
// Depends on ctp_pkg; holds the output register of the block.
module ctp_calc (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sum_valid,
  output logic                               sum_ready,
  input  ctp_pkg::summary_t                  sum,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ctp_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import ctp_pkg::*;

  result_t     res;
  logic [31:0] mask, net, bc;

  assign sum_ready = !m_tvalid || m_tready;

  always_comb begin
    mask = (sum.prefix == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (PREFIX_MAX - sum.prefix));
    net  = sum.address & mask;
    bc   = net | ~mask;
    res  = '0;
    res.status = sum.status;
    if (sum.status == ST_OK) begin
      res.prefix_length = sum.prefix;
      res.network       = net;
      res.netmask       = mask;
      res.broadcast     = bc;
      if (sum.prefix < PREFIX_P2P) begin
        res.host_low   = net + 32'd1;
        res.host_high  = bc - 32'd1;
        res.host_count = ~mask - 32'd1;
      end else if (sum.prefix == PREFIX_P2P) begin
        res.host_low   = net;
        res.host_high  = net + 32'd1;
        res.host_count = 32'd2;
      end else begin
        res.host_low   = net;
        res.host_high  = net;
        res.host_count = 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sum_ready) begin
      m_tvalid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) m_tdata <= res;
  end

endmodule
